[hdl/assert_macros.svh]
// Assertion helpers for the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, ignored while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/fsec_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package fsec_pkg;

   // Queue between front and back
   localparam int JOB_DEPTH = 4;

   // Configuration register indexes
   typedef enum logic [2:0] {
      CSR_BATTERY_MIN  = 3'd0,
      CSR_ALT_CEILING  = 3'd1,
      CSR_FENCE_X_LOW  = 3'd2,
      CSR_FENCE_X_HIGH = 3'd3,
      CSR_FENCE_Z_LOW  = 3'd4,
      CSR_FENCE_Z_HIGH = 3'd5,
      CSR_ZONE_COUNT   = 3'd6
   } csr_reg_type;

   // Violation codes
   typedef enum logic [2:0] {
      VIOL_NONE      = 3'd0,
      VIOL_EMERGENCY = 3'd1,
      VIOL_BATTERY   = 3'd2,
      VIOL_ALTITUDE  = 3'd3,
      VIOL_GEOFENCE  = 3'd4,
      VIOL_NOFLY     = 3'd5
   } viol_type;

   // What the back end has to do with a queued job
   typedef enum logic [1:0] {
      JOB_LOAD  = 2'd0,
      JOB_DONE  = 2'd1,
      JOB_SCAN  = 2'd2
   } job_kind_type;

   typedef enum logic [1:0] {
      BK_IDLE  = 2'd0,
      BK_SCAN  = 2'd1,
      BK_REPLY = 2'd2
   } back_state_type;

   typedef struct packed {
      logic               func;
      logic signed [19:0] pos_x;
      logic signed [19:0] pos_y;
      logic signed [19:0] pos_z;
      logic        [9:0]  battery_level;
      logic        [15:0] waypoint_in;
      logic               abort_request;
      logic        [2:0]  zone_slot;
      logic signed [19:0] zone_x;
      logic signed [19:0] zone_z;
      logic        [15:0] zone_radius;
   } req_type;

   typedef struct packed {
      logic [2:0]  violation_code;
      logic [2:0]  hit_zone;
      logic [15:0] waypoint_out;
   } rsp_type;

   // Classified request; pt_x/pt_z are the sample position or the zone centre
   typedef struct packed {
      job_kind_type       kind;
      viol_type           code;
      logic        [15:0] waypoint;
      logic        [2:0]  slot;
      logic signed [19:0] pt_x;
      logic signed [19:0] pt_z;
      logic        [15:0] radius;
   } job_type;

   // Queue port toward the back end
   typedef struct packed {
      logic    valid;
      job_type data;
   } job_port_type;

endpackage

`default_nettype wire

[hdl/fsec_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module fsec_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire fsec_pkg::req_type req_data,
   input  wire logic             csr_write_en,
   input  wire logic [2:0]       csr_index,
   input  wire logic [19:0]      csr_wdata,
   input  wire logic             job_full,
   output logic                  job_wr,
   output fsec_pkg::job_type     job_data,
   output logic [3:0]            zone_count
);

   logic        [9:0]  batt_min_ff;
   logic signed [19:0] alt_ceil_ff;
   logic signed [19:0] fx_low_ff;
   logic signed [19:0] fx_high_ff;
   logic signed [19:0] fz_low_ff;
   logic signed [19:0] fz_high_ff;
   logic        [3:0]  zone_cnt_ff;
   logic               out_fence;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         batt_min_ff <= 10'd0;
         alt_ceil_ff <= 20'sh7FFFF;
         fx_low_ff   <= 20'sh80000;
         fx_high_ff  <= 20'sh7FFFF;
         fz_low_ff   <= 20'sh80000;
         fz_high_ff  <= 20'sh7FFFF;
         zone_cnt_ff <= 4'd0;
      end else if (csr_write_en) begin
         case (csr_index)
            fsec_pkg::CSR_BATTERY_MIN:  batt_min_ff <= csr_wdata[9:0];
            fsec_pkg::CSR_ALT_CEILING:  alt_ceil_ff <= csr_wdata;
            fsec_pkg::CSR_FENCE_X_LOW:  fx_low_ff   <= csr_wdata;
            fsec_pkg::CSR_FENCE_X_HIGH: fx_high_ff  <= csr_wdata;
            fsec_pkg::CSR_FENCE_Z_LOW:  fz_low_ff   <= csr_wdata;
            fsec_pkg::CSR_FENCE_Z_HIGH: fz_high_ff  <= csr_wdata;
            fsec_pkg::CSR_ZONE_COUNT:   zone_cnt_ff <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   assign zone_count = zone_cnt_ff;
   assign job_wr     = push && !job_full;

   assign out_fence = (req_data.pos_x < fx_low_ff) || (req_data.pos_x > fx_high_ff) ||
                      (req_data.pos_z < fz_low_ff) || (req_data.pos_z > fz_high_ff);

   // Priority classification; only zone loads and the zone check are left for the back end
   always_comb begin
      job_data.kind     = fsec_pkg::JOB_DONE;
      job_data.code     = fsec_pkg::VIOL_NONE;
      job_data.waypoint = req_data.waypoint_in;
      job_data.slot     = req_data.zone_slot;
      job_data.pt_x     = req_data.pos_x;
      job_data.pt_z     = req_data.pos_z;
      job_data.radius   = req_data.zone_radius;
      if (req_data.func) begin
         job_data.kind = fsec_pkg::JOB_LOAD;
         job_data.pt_x = req_data.zone_x;
         job_data.pt_z = req_data.zone_z;
      end else if (req_data.abort_request) begin
         job_data.code = fsec_pkg::VIOL_EMERGENCY;
      end else if (req_data.battery_level <= batt_min_ff) begin
         job_data.code = fsec_pkg::VIOL_BATTERY;
      end else if (req_data.pos_y > alt_ceil_ff) begin
         job_data.code = fsec_pkg::VIOL_ALTITUDE;
      end else if (out_fence) begin
         job_data.code = fsec_pkg::VIOL_GEOFENCE;
      end else begin
         job_data.kind = fsec_pkg::JOB_SCAN;
      end
   end

endmodule

`default_nettype wire

[hdl/fsec_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none

module fsec_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire fsec_pkg::job_type wr_data,
   output logic                   full,
   input  wire logic              rd_en,
   output fsec_pkg::job_port_type rd_port
);

   localparam int PW = $clog2(fsec_pkg::JOB_DEPTH);
   localparam int CW = $clog2(fsec_pkg::JOB_DEPTH + 1);

   fsec_pkg::job_type slot_ff [fsec_pkg::JOB_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          do_wr, do_rd;

   assign full  = (cnt_ff == CW'(fsec_pkg::JOB_DEPTH));
   assign do_wr = wr_en && !full;
   assign do_rd = rd_en && (cnt_ff != '0);

   // Pointers and fill count
   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   assign rd_port.valid = (cnt_ff != '0);
   assign rd_port.data  = slot_ff[rd_ptr_ff];

endmodule

`default_nettype wire

[hdl/fsec_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module fsec_back #(
   parameter int MAX_ZONES = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire fsec_pkg::job_port_type job_port,
   output logic                        job_rd,
   input  wire logic [3:0]             zone_count,
   output logic                        empty,
   input  wire logic                   pop,
   output fsec_pkg::rsp_type           rsp_data
);

   localparam int IW = (MAX_ZONES > 1) ? $clog2(MAX_ZONES) : 1;
   localparam int CW = $clog2(MAX_ZONES + 1);

   // Zone table, undefined until loaded
   logic signed [19:0] zone_x_mem [MAX_ZONES];
   logic signed [19:0] zone_z_mem [MAX_ZONES];
   logic        [15:0] zone_r_mem [MAX_ZONES];

   fsec_pkg::back_state_type state_ff, state_in;
   fsec_pkg::job_type        cur_ff, cur_in;
   logic [CW-1:0]            limit_ff, limit_in;
   logic [CW-1:0]            iss_cnt_ff, iss_cnt_in;
   fsec_pkg::viol_type       res_code_ff, res_code_in;
   logic [2:0]               res_hit_ff, res_hit_in;

   // Scan pipeline: table read, squares, compare
   logic               s1_vld_ff, s1_vld_in;
   logic [IW-1:0]      s1_idx_ff;
   logic signed [19:0] rd_x_ff, rd_z_ff;
   logic        [15:0] rd_r_ff;
   logic               s2_vld_ff, s2_vld_in;
   logic [IW-1:0]      s2_idx_ff;
   logic [40:0]        sq_dx_ff, sq_dz_ff;
   logic [31:0]        sq_r_ff;

   logic               out_vld_ff, out_vld_in;
   fsec_pkg::rsp_type  out_ff;

   logic               iss_en, mem_we, load_out, zone_hit, pipe_busy;
   logic signed [20:0] dx, dz;
   logic signed [41:0] dx_sq, dz_sq;
   logic        [41:0] dist_sq;

   // Squared distance to the zone read last cycle
   assign dx    = 21'(cur_ff.pt_x) - 21'(rd_x_ff);
   assign dz    = 21'(cur_ff.pt_z) - 21'(rd_z_ff);
   assign dx_sq = dx * dx;
   assign dz_sq = dz * dz;

   assign dist_sq   = {1'b0, sq_dx_ff} + {1'b0, sq_dz_ff};
   assign zone_hit  = s2_vld_ff && (dist_sq <= {10'd0, sq_r_ff});
   assign pipe_busy = s1_vld_ff || s2_vld_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fsec_pkg::BK_IDLE: begin
            if (job_port.valid) begin
               case (job_port.data.kind)
                  fsec_pkg::JOB_DONE: state_in = fsec_pkg::BK_REPLY;
                  fsec_pkg::JOB_SCAN: state_in = fsec_pkg::BK_SCAN;
                  default:            state_in = fsec_pkg::BK_IDLE;
               endcase
            end
         end
         fsec_pkg::BK_SCAN: begin
            if (zone_hit || (!iss_en && !pipe_busy)) begin
               state_in = fsec_pkg::BK_REPLY;
            end
         end
         fsec_pkg::BK_REPLY: begin
            if (load_out) begin
               state_in = fsec_pkg::BK_IDLE;
            end
         end
         default: state_in = fsec_pkg::BK_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      job_rd   = 1'b0;
      mem_we   = 1'b0;
      iss_en   = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         fsec_pkg::BK_IDLE: begin
            job_rd = job_port.valid;
            mem_we = job_port.valid && (job_port.data.kind == fsec_pkg::JOB_LOAD) &&
                     (int'(job_port.data.slot) < MAX_ZONES);
         end
         fsec_pkg::BK_SCAN: begin
            iss_en = (iss_cnt_ff < limit_ff) && !zone_hit;
         end
         fsec_pkg::BK_REPLY: begin
            load_out = !out_vld_ff || pop;
         end
         default: ;
      endcase
   end

   // Datapath next values
   always_comb begin
      cur_in      = cur_ff;
      limit_in    = limit_ff;
      iss_cnt_in  = iss_cnt_ff;
      res_code_in = res_code_ff;
      res_hit_in  = res_hit_ff;
      if (state_ff == fsec_pkg::BK_IDLE && job_port.valid) begin
         cur_in      = job_port.data;
         res_code_in = job_port.data.code;
         res_hit_in  = 3'd0;
         iss_cnt_in  = '0;
         if (int'(zone_count) > MAX_ZONES) begin
            limit_in = CW'(MAX_ZONES);
         end else begin
            limit_in = CW'(zone_count);
         end
      end
      if (iss_en) begin
         iss_cnt_in = iss_cnt_ff + 1'b1;
      end
      if (state_ff == fsec_pkg::BK_SCAN && zone_hit) begin
         res_code_in = fsec_pkg::VIOL_NOFLY;
         res_hit_in  = 3'(s2_idx_ff);
      end
      s1_vld_in  = iss_en;
      s2_vld_in  = s1_vld_ff && !zone_hit;
      out_vld_in = out_vld_ff;
      if (pop) begin
         out_vld_in = 1'b0;
      end
      if (load_out) begin
         out_vld_in = 1'b1;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= fsec_pkg::BK_IDLE;
         iss_cnt_ff <= '0;
         s1_vld_ff  <= 1'b0;
         s2_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         iss_cnt_ff <= iss_cnt_in;
         s1_vld_ff  <= s1_vld_in;
         s2_vld_ff  <= s2_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff      <= cur_in;
      limit_ff    <= limit_in;
      res_code_ff <= res_code_in;
      res_hit_ff  <= res_hit_in;
      s1_idx_ff   <= iss_cnt_ff[IW-1:0];
      s2_idx_ff   <= s1_idx_ff;
      sq_dx_ff    <= dx_sq[40:0];
      sq_dz_ff    <= dz_sq[40:0];
      sq_r_ff     <= rd_r_ff * rd_r_ff;
      if (load_out) begin
         out_ff.violation_code <= res_code_ff;
         out_ff.hit_zone       <= res_hit_ff;
         out_ff.waypoint_out   <= cur_ff.waypoint;
      end
   end

   // Zone table write and registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         zone_x_mem[IW'(job_port.data.slot)] <= job_port.data.pt_x;
         zone_z_mem[IW'(job_port.data.slot)] <= job_port.data.pt_z;
         zone_r_mem[IW'(job_port.data.slot)] <= job_port.data.radius;
      end
      if (iss_en) begin
         rd_x_ff <= zone_x_mem[iss_cnt_ff[IW-1:0]];
         rd_z_ff <= zone_z_mem[iss_cnt_ff[IW-1:0]];
         rd_r_ff <= zone_r_mem[iss_cnt_ff[IW-1:0]];
      end
   end

   assign empty    = !out_vld_ff;
   assign rsp_data = out_ff;

endmodule

`default_nettype wire

[hdl/flight_safety_envelope_check.sv]
// Flow: an evaluate request with an early violation goes from the queue through the
// back end's reply state to the result register; one that reaches the zone check
// first scans the zones, up to the first hit or the end of the zone count.
// Throughput: a 4-entry queue takes a request every cycle until full; the back end
// retires a load per cycle while idle and takes no new sample until the last is done.
// Reset is synchronous, active high; the zone table is undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module flight_safety_envelope_check #(
   parameter int MAX_ZONES = 8
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   output logic                   full,
   input  wire fsec_pkg::req_type req_data,
   output logic                   empty,
   input  wire logic              pop,
   output fsec_pkg::rsp_type      rsp_data,
   input  wire logic              csr_write_en,
   input  wire logic [2:0]        csr_index,
   input  wire logic [19:0]       csr_wdata
);

   logic                   job_wr;
   logic                   job_rd;
   fsec_pkg::job_type      job_data;
   fsec_pkg::job_port_type job_port;
   logic [3:0]             zone_count;

   fsec_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .req_data     (req_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .job_full     (full),
      .job_wr       (job_wr),
      .job_data     (job_data),
      .zone_count   (zone_count)
   );

   fsec_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (job_wr),
      .wr_data (job_data),
      .full    (full),
      .rd_en   (job_rd),
      .rd_port (job_port)
   );

   fsec_back #(
      .MAX_ZONES (MAX_ZONES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_port   (job_port),
      .job_rd     (job_rd),
      .zone_count (zone_count),
      .empty      (empty),
      .pop        (pop),
      .rsp_data   (rsp_data)
   );

   // An accepted request is always waiting in the queue the next cycle
   `ASSERT_NEXT(a_req_queued, clock, reset, push && !full, job_port.valid, "request lost")
   // The back end only takes jobs that are present
   `ASSERT_SAME(a_rd_valid, clock, reset, job_rd, job_port.valid, "queue underflow")
   // An empty queue with no request offered stays below full
   `ASSERT_NEXT(a_no_jump, clock, reset, !job_port.valid && !push, !full, "queue count broken")

endmodule

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

   localparam int ZONE_SLOTS     = 8;
   localparam int DRAIN_CYCLES   = 32;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 210;
   // index past the last register; the block must ignore writes to it
   localparam logic [2:0] CSR_NO_REG = 3'd7;

   // Prediction of the envelope verdicts and check of what comes back
   class envelope_scoreboard;
      int failures;
      fsec_pkg::rsp_type verdicts_due[$];
      logic        [9:0]  battery_min;
      logic signed [19:0] ceiling;
      logic signed [19:0] x_lo, x_hi, z_lo, z_hi;
      logic        [3:0]  zone_count;
      logic signed [19:0] centre_x[ZONE_SLOTS];
      logic signed [19:0] centre_z[ZONE_SLOTS];
      logic        [15:0] radius[ZONE_SLOTS];

      function new();
         failures    = 0;
         battery_min = '0;
         ceiling     = 20'sd524287;
         x_lo        = -20'sd524288;
         x_hi        = 20'sd524287;
         z_lo        = -20'sd524288;
         z_hi        = 20'sd524287;
         zone_count  = '0;
      endfunction

      function void write_reg(logic [2:0] idx, logic [19:0] value);
         case (idx)
            fsec_pkg::CSR_BATTERY_MIN:  battery_min = value[9:0];
            fsec_pkg::CSR_ALT_CEILING:  ceiling = value;
            fsec_pkg::CSR_FENCE_X_LOW:  x_lo = value;
            fsec_pkg::CSR_FENCE_X_HIGH: x_hi = value;
            fsec_pkg::CSR_FENCE_Z_LOW:  z_lo = value;
            fsec_pkg::CSR_FENCE_Z_HIGH: z_hi = value;
            fsec_pkg::CSR_ZONE_COUNT:   zone_count = value[3:0];
            default: ;
         endcase
      endfunction

      function void note_request(fsec_pkg::req_type r);
         fsec_pkg::rsp_type verdict;
         int scan;
         longint dx, dz, rr;
         // zone load: table write, nothing comes back
         if (r.func) begin
            centre_x[r.zone_slot] = r.zone_x;
            centre_z[r.zone_slot] = r.zone_z;
            radius[r.zone_slot]   = r.zone_radius;
            return;
         end
         verdict.violation_code = fsec_pkg::VIOL_NONE;
         verdict.hit_zone       = '0;
         verdict.waypoint_out   = r.waypoint_in;
         // fixed priority order
         if (r.abort_request)
            verdict.violation_code = fsec_pkg::VIOL_EMERGENCY;
         else if (r.battery_level <= battery_min)
            verdict.violation_code = fsec_pkg::VIOL_BATTERY;
         else if ($signed(r.pos_y) > ceiling)
            verdict.violation_code = fsec_pkg::VIOL_ALTITUDE;
         else if ($signed(r.pos_x) < x_lo || $signed(r.pos_x) > x_hi ||
                  $signed(r.pos_z) < z_lo || $signed(r.pos_z) > z_hi)
            verdict.violation_code = fsec_pkg::VIOL_GEOFENCE;
         else begin
            // first zone in slot order whose squared distance fits
            scan = (zone_count > ZONE_SLOTS) ? ZONE_SLOTS : int'(zone_count);
            for (int i = 0; i < scan; i++) begin
               dx = longint'($signed(r.pos_x)) - longint'(centre_x[i]);
               dz = longint'($signed(r.pos_z)) - longint'(centre_z[i]);
               rr = longint'(radius[i]);
               if (dx * dx + dz * dz <= rr * rr) begin
                  verdict.violation_code = fsec_pkg::VIOL_NOFLY;
                  verdict.hit_zone       = 3'(i);
                  break;
               end
            end
         end
         verdicts_due = {verdicts_due, verdict};
      endfunction

      function void check_response(fsec_pkg::rsp_type got);
         fsec_pkg::rsp_type want;
         if (verdicts_due.size() == 0) begin
            $error("response with no request waiting: code %0d waypoint %0d",
                   got.violation_code, got.waypoint_out);
            failures++;
            return;
         end
         want = verdicts_due.pop_front();
         if (got.violation_code !== want.violation_code) begin
            $error("violation_code expected %0d actual %0d",
                   want.violation_code, got.violation_code);
            failures++;
         end
         if (got.hit_zone !== want.hit_zone) begin
            $error("hit_zone expected %0d actual %0d", want.hit_zone, got.hit_zone);
            failures++;
         end
         if (got.waypoint_out !== want.waypoint_out) begin
            $error("waypoint_out expected %0d actual %0d",
                   want.waypoint_out, got.waypoint_out);
            failures++;
         end
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              push = 1'b0;
   logic              full;
   fsec_pkg::req_type req_data = '0;
   logic              empty;
   logic              pop = 1'b0;
   fsec_pkg::rsp_type rsp_data;
   logic              csr_write_en = 1'b0;
   logic [2:0]        csr_index = '0;
   logic [19:0]       csr_wdata = '0;

   envelope_scoreboard sb;
   bit calm = 1'b0;
   int idle_cycles = 0;

   flight_safety_envelope_check #(.MAX_ZONES(ZONE_SLOTS)) dut (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_data     (req_data),
      .empty        (empty),
      .pop          (pop),
      .rsp_data     (rsp_data),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic int rand_between(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   // Offer one request, hold it until accepted
   task automatic send_request(fsec_pkg::req_type r);
      while (!calm && $urandom_range(99) < 16) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push     <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (full);
      sb.note_request(r);
   endtask

   // Evaluate request; load-only fields carry noise
   task automatic send_eval(int x, int y, int z, int batt, int wp, bit abort_req);
      fsec_pkg::req_type r;
      r.func          = 1'b0;
      r.pos_x         = 20'(x);
      r.pos_y         = 20'(y);
      r.pos_z         = 20'(z);
      r.battery_level = 10'(batt);
      r.waypoint_in   = 16'(wp);
      r.abort_request = abort_req;
      r.zone_slot     = 3'($urandom);
      r.zone_x        = 20'($urandom);
      r.zone_z        = 20'($urandom);
      r.zone_radius   = 16'($urandom);
      send_request(r);
   endtask

   // Zone load request; sample fields carry noise
   task automatic send_load(int slot, int x, int z, int rad);
      fsec_pkg::req_type r;
      r.func          = 1'b1;
      r.pos_x         = 20'($urandom);
      r.pos_y         = 20'($urandom);
      r.pos_z         = 20'($urandom);
      r.battery_level = 10'($urandom);
      r.waypoint_in   = 16'($urandom);
      r.abort_request = 1'($urandom);
      r.zone_slot     = 3'(slot);
      r.zone_x        = 20'(x);
      r.zone_z        = 20'(z);
      r.zone_radius   = 16'(rad);
      send_request(r);
   endtask

   // Block idle: every verdict back, then room for a trailing load or scan
   task automatic settle();
      push <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, int value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= 20'(value);
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.write_reg(idx, 20'(value));
      @(posedge clock);
   endtask

   task automatic apply_setting(int batt, int ceil, int xl, int xh, int zl, int zh,
                                int count);
      settle();
      write_csr(fsec_pkg::CSR_BATTERY_MIN, batt);
      write_csr(fsec_pkg::CSR_ALT_CEILING, ceil);
      write_csr(fsec_pkg::CSR_FENCE_X_LOW, xl);
      write_csr(fsec_pkg::CSR_FENCE_X_HIGH, xh);
      write_csr(fsec_pkg::CSR_FENCE_Z_LOW, zl);
      write_csr(fsec_pkg::CSR_FENCE_Z_HIGH, zh);
      write_csr(fsec_pkg::CSR_ZONE_COUNT, count);
   endtask

   // Random traffic, biased toward samples that get past the early checks
   task automatic run_phase(int items);
      fsec_pkg::req_type r;
      int pick, slot, span;
      for (int n = 0; n < items; n++) begin
         r.func          = 1'b0;
         r.pos_x         = 20'($urandom);
         r.pos_y         = 20'($urandom);
         r.pos_z         = 20'($urandom);
         r.battery_level = 10'($urandom);
         r.waypoint_in   = 16'($urandom);
         r.abort_request = ($urandom_range(99) < 6);
         r.zone_slot     = 3'($urandom);
         r.zone_x        = 20'($urandom);
         r.zone_z        = 20'($urandom);
         r.zone_radius   = 16'($urandom);
         if ($urandom_range(99) < 10) begin
            // reload a zone, mostly near the middle of the fence
            r.func = 1'b1;
            if ($urandom_range(1)) begin
               r.zone_x = 20'(rand_between(-65536, 65536));
               r.zone_z = 20'(rand_between(-65536, 65536));
            end
            pick = $urandom_range(2);
            if (pick == 0) r.zone_radius = 16'($urandom_range(15));
            else if (pick == 1) r.zone_radius = 16'(rand_between(1000, 20000));
         end else begin
            if ($urandom_range(99) < 80 && sb.battery_min != 10'h3ff)
               r.battery_level = 10'(rand_between(int'(sb.battery_min) + 1, 1023));
            if ($urandom_range(99) < 70)
               r.pos_y = 20'(rand_between(-524288, int'(sb.ceiling)));
            pick = $urandom_range(99);
            if (pick < 45) begin
               // around a stored zone, both sides of its edge
               slot = $urandom_range(ZONE_SLOTS - 1);
               span = int'(sb.radius[slot]) + int'(sb.radius[slot]) / 8 + 2;
               r.pos_x = 20'(int'(sb.centre_x[slot]) + rand_between(-span, span));
               r.pos_z = 20'(int'(sb.centre_z[slot]) + rand_between(-span, span));
            end else if (pick < 70) begin
               // on the fence edges
               r.pos_x = 20'(($urandom_range(1) ? int'(sb.x_lo) : int'(sb.x_hi)) +
                             rand_between(-2, 2));
               r.pos_z = 20'(($urandom_range(1) ? int'(sb.z_lo) : int'(sb.z_hi)) +
                             rand_between(-2, 2));
            end else if (pick < 85 && sb.x_lo <= sb.x_hi && sb.z_lo <= sb.z_hi) begin
               r.pos_x = 20'(rand_between(int'(sb.x_lo), int'(sb.x_hi)));
               r.pos_z = 20'(rand_between(int'(sb.z_lo), int'(sb.z_hi)));
            end
         end
         send_request(r);
      end
   endtask

   // Result side: random stalls unless in a calm stretch
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else begin
         if (pop && !empty) sb.check_response(rsp_data);
         pop <= calm || ($urandom_range(99) >= 16);
      end
   end

   // Watchdog on cycles with no request or response moving
   always @(posedge clock) begin
      if (reset || (push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("flight_safety_envelope_check verification failed");
         $finish;
      end
   end

   initial begin
      sb = new();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings, empty zone list
      send_eval(0, 0, 0, 0, 0, 1'b0);
      send_eval(0, 0, 0, 0, 1, 1'b1);
      send_eval(524287, 524287, 524287, 1023, 65535, 1'b0);
      send_eval(-524288, -524288, -524288, 1, 32768, 1'b0);

      // fill the whole table before any zone is scanned
      send_load(0, 1000, 1000, 5);
      send_load(1, -2000, 3000, 0);
      send_load(2, -300000, -300000, 65535);
      send_load(3, 524287, -524288, 65535);
      send_load(4, 200000, 200000, 100);
      send_load(5, -100000, 50000, 1);
      send_load(6, 300000, -50000, 7);
      send_load(7, 0, 400000, 20000);

      // zone edges, zero radius, largest radius
      apply_setting(0, 524287, -524288, 524287, -524288, 524287, 8);
      send_eval(1003, 0, 1004, 500, 10, 1'b0);
      send_eval(1003, 0, 1005, 500, 11, 1'b0);
      send_eval(-2000, 0, 3000, 500, 12, 1'b0);
      send_eval(-2001, 0, 3000, 500, 13, 1'b0);
      send_eval(-234465, 0, -300000, 500, 14, 1'b0);
      send_eval(-234464, 0, -300000, 500, 15, 1'b0);
      send_eval(524287, 0, -524288, 500, 16, 1'b0);

      // battery, altitude and fence limits
      apply_setting(1000, 0, -100, 100, -50, 50, 8);
      send_eval(0, 0, 0, 1000, 20, 1'b0);
      send_eval(0, 1, 0, 1001, 21, 1'b0);
      send_eval(101, 0, 0, 1023, 22, 1'b0);
      send_eval(-101, 0, 0, 1023, 23, 1'b0);
      send_eval(0, 0, 51, 1023, 24, 1'b0);
      send_eval(0, 0, -51, 1023, 25, 1'b0);
      send_eval(100, 0, 50, 1001, 26, 1'b0);

      // inverted fence; write to the unused index is dropped
      apply_setting(5, 524287, 10, -10, -524288, 524287, 12);
      write_csr(CSR_NO_REG, 20'hfffff);
      send_eval(0, 0, 0, 6, 30, 1'b0);

      // zone count above the table size still reaches the last slots
      apply_setting(0, 524287, -524288, 524287, -524288, 524287, 12);
      send_eval(300005, 0, -50000, 500, 31, 1'b0);
      send_eval(0, 0, 420000, 500, 32, 1'b0);

      apply_setting(1023, 524287, -524288, 524287, -524288, 524287, 8);
      send_eval(0, 0, 0, 1023, 33, 1'b0);

      // random phases over a spread of settings
      apply_setting(0, 524287, -524288, 524287, -524288, 524287, 8);
      run_phase(PHASE_ITEMS);
      apply_setting(rand_between(0, 1000), rand_between(0, 131072),
                    rand_between(-131072, -1000), rand_between(1000, 131072),
                    rand_between(-131072, -1000), rand_between(1000, 131072),
                    rand_between(1, 8));
      run_phase(PHASE_ITEMS);
      apply_setting(rand_between(0, 200), 524287, -131072, 131072, 1000, -1000, 15);
      run_phase(PHASE_ITEMS);
      apply_setting(1000, -524288, -524288, 524287, -524288, 524287, 9);
      run_phase(PHASE_ITEMS);
      apply_setting(rand_between(0, 1000), rand_between(0, 131072),
                    rand_between(-131072, -1000), rand_between(1000, 131072),
                    rand_between(-131072, -1000), rand_between(1000, 131072),
                    rand_between(9, 15));
      run_phase(PHASE_ITEMS);
      // no stalls on either side for this stretch
      apply_setting(rand_between(0, 500), rand_between(0, 131072),
                    rand_between(-131072, -1000), rand_between(1000, 131072),
                    rand_between(-131072, -1000), rand_between(1000, 131072), 8);
      calm = 1'b1;
      run_phase(PHASE_ITEMS);
      calm = 1'b0;

      settle();
      if (sb.failures == 0 && sb.pending() == 0)
         $display("flight_safety_envelope_check verification clean");
      else
         $display("flight_safety_envelope_check verification failed");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/fsec_pkg.sv
hdl/fsec_front.sv
hdl/fsec_fifo.sv
hdl/fsec_back.sv
hdl/flight_safety_envelope_check.sv
sim/tb_top.sv
